// ===== hdl/cosine_palette_color_defines.svh =====
// Assertion macros for the cosine palette color block.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef COSINE_PALETTE_COLOR_DEFINES_SVH
`define COSINE_PALETTE_COLOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cpc_pkg.sv =====
// Package for the cosine palette color block: field types, register indexes,
// reset values and the elaboration-time cosine table generator. No dependencies.
package cpc_pkg;

  localparam int POSITION_W  = 16;
  localparam int COLOR_W     = 8;
  localparam int LEVEL_W     = 8;
  localparam int FREQ_W      = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam int PHASE_BITS_DEF    = 16;
  localparam int TABLE_BITS_DEF    = 10;
  localparam int COS_FRAC_BITS_DEF = 14;

  typedef logic [POSITION_W-1:0]  position_t;
  typedef logic [COLOR_W-1:0]     color_t;
  typedef logic [LEVEL_W-1:0]     level_t;
  typedef logic [FREQ_W-1:0]      freq_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  localparam cfg_index_t REG_BASE_LEVEL = 3'd0;
  localparam cfg_index_t REG_SWING      = 3'd1;
  localparam cfg_index_t REG_FREQ_RED   = 3'd2;
  localparam cfg_index_t REG_FREQ_GREEN = 3'd3;
  localparam cfg_index_t REG_FREQ_BLUE  = 3'd4;

  localparam level_t BASE_LEVEL_RST = 8'd128;
  localparam level_t SWING_RST      = 8'd100;
  localparam freq_t  FREQ_RST       = 4'd1;

  localparam logic [63:0] Q_ONE   = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
  localparam int          TAYLOR_TERMS = 12;

  // (a * b) >> 60, kept to 64 bits
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Taylor step divisor (2k-1)(2k)
  function automatic logic [63:0] taylor_div(logic [63:0] v, int k);
    logic [63:0] r;
    case (k)
      12:      r = v / 64'd552;
      11:      r = v / 64'd462;
      10:      r = v / 64'd380;
      9:       r = v / 64'd306;
      8:       r = v / 64'd240;
      7:       r = v / 64'd182;
      6:       r = v / 64'd132;
      5:       r = v / 64'd90;
      4:       r = v / 64'd56;
      3:       r = v / 64'd30;
      2:       r = v / 64'd12;
      default: r = v / 64'd2;
    endcase
    return r;
  endfunction

  // cos(2*pi*m/2^tb) in Q60 for the first quarter period
  function automatic logic [63:0] quarter_cos(logic [63:0] m, int tb);
    logic [63:0] quarter;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] d;
    quarter = 64'd1 << (tb - 2);
    if (m == 64'd0) begin
      return Q_ONE;
    end
    if (m >= quarter) begin
      return 64'd0;
    end
    x = m * (PI_Q60 >> (tb - 1));
    y = mul_q60(x, x);
    t = Q_ONE;
    for (int k = TAYLOR_TERMS; k >= 1; k--) begin
      d = taylor_div(mul_q60(y, t), k);
      t = (d > Q_ONE) ? 64'd0 : Q_ONE - d;
    end
    return t;
  endfunction

  // Signed table entry, rounded to fb fraction bits
  function automatic longint cos_entry(logic [63:0] k_in, int tb, int fb);
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] h;
    logic [63:0] k;
    logic [63:0] m;
    logic [63:0] c;
    logic        neg;
    n = 64'd1 << tb;
    q = n >> 2;
    h = n >> 1;
    k = k_in & (n - 64'd1);
    if (k <= q) begin
      m = k;
      neg = 1'b0;
    end else if (k <= h) begin
      m = h - k;
      neg = 1'b1;
    end else if (k <= h + q) begin
      m = k - h;
      neg = 1'b1;
    end else begin
      m = n - k;
      neg = 1'b0;
    end
    c = quarter_cos(m, tb);
    c = (c + (64'd1 << (59 - fb))) >> (60 - fb);
    return neg ? -longint'(c) : longint'(c);
  endfunction

endpackage

// ===== hdl/cpc_pos_if.sv =====
// Input channel of the cosine palette color block: one gradient position per beat.
// Depends on cpc_pkg.
interface cpc_pos_if;
  import cpc_pkg::*;

  logic      valid;
  logic      ready;
  position_t position;

  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface

// ===== hdl/cpc_color_if.sv =====
// Output channel of the cosine palette color block: one RGB color per beat.
// Depends on cpc_pkg.
interface cpc_color_if;
  import cpc_pkg::*;

  logic   valid;
  logic   ready;
  color_t red;
  color_t green;
  color_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hdl/cpc_cfg_if.sv =====
// Register write channel of the cosine palette color block: index and data per beat.
// Depends on cpc_pkg.
interface cpc_cfg_if;
  import cpc_pkg::*;

  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/cosine_palette_color.sv =====
// Cosine palette color: gradient position in, clamped RGB color out.
// Pipeline stages from input beat to output beat: phase, quarter-wave lookup, multiply, clamp.
// Throughput: one color per cycle; all four stages advance on one shared enable,
// held only while the output register holds an untaken beat.
// Reset (rst, synchronous): base 128, swing 100, all frequencies 1, pipeline empty.
// Depends on cpc_pkg, the cpc_*_if interfaces and cosine_palette_color_defines.svh.
`include "cosine_palette_color_defines.svh"

module cosine_palette_color #(
  parameter int PHASE_BITS    = cpc_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS    = cpc_pkg::TABLE_BITS_DEF,
  parameter int COS_FRAC_BITS = cpc_pkg::COS_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cpc_cfg_if.sink     cfg,
  cpc_pos_if.sink     pixel_in,
  cpc_color_if.source color_out
);
  import cpc_pkg::*;

  localparam int NCH      = 3;
  localparam int QTR_BITS = TABLE_BITS - 2;
  localparam int QTR_SIZE = 1 << QTR_BITS;
  localparam int MAG_W    = COS_FRAC_BITS + 1;
  localparam int PROD_W   = LEVEL_W + MAG_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int QUOT_W   = NUM_W - COS_FRAC_BITS;
  localparam int MULT_W   = PHASE_BITS + FREQ_W;

  // Registers
  level_t base_level;
  level_t swing;
  freq_t  freq [NCH];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_level <= BASE_LEVEL_RST;
      swing      <= SWING_RST;
      freq[0]    <= FREQ_RST;
      freq[1]    <= FREQ_RST;
      freq[2]    <= FREQ_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_BASE_LEVEL: base_level <= cfg.data[LEVEL_W-1:0];
        REG_SWING:      swing      <= cfg.data[LEVEL_W-1:0];
        REG_FREQ_RED:   freq[0]    <= cfg.data[FREQ_W-1:0];
        REG_FREQ_GREEN: freq[1]    <= cfg.data[FREQ_W-1:0];
        REG_FREQ_BLUE:  freq[2]    <= cfg.data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Cosine magnitude, first quarter period
  logic [MAG_W-1:0] cos_rom [QTR_SIZE];

  for (genvar g = 0; g < QTR_SIZE; g++) begin : g_rom
    assign cos_rom[g] = MAG_W'(cos_entry(64'(g), TABLE_BITS, COS_FRAC_BITS));
  end

  // Pipeline control
  logic       s1_valid;
  logic       s2_valid;
  logic       s3_valid;
  logic       out_valid;
  logic       adv;
  logic       in_fire;
  logic       out_stall;
  logic [3:0] valid_vec;

  assign adv            = !out_valid || color_out.ready;
  assign pixel_in.ready = adv;
  assign in_fire        = pixel_in.valid && pixel_in.ready;
  assign out_stall      = out_valid && !color_out.ready;
  assign valid_vec      = {s1_valid, s2_valid, s3_valid, out_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= pixel_in.valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  // Stage 1: position to phase
  logic [PHASE_BITS-1:0] pos_scaled;

  if (PHASE_BITS > POSITION_W) begin : g_pos_up
    assign pos_scaled = {pixel_in.position, {(PHASE_BITS - POSITION_W){1'b0}}};
  end else if (PHASE_BITS == POSITION_W) begin : g_pos_eq
    assign pos_scaled = pixel_in.position;
  end else begin : g_pos_dn
    assign pos_scaled = pixel_in.position[POSITION_W-1 -: PHASE_BITS];
  end

  logic [MULT_W-1:0]     phase_full [NCH];
  logic [PHASE_BITS-1:0] s1_phase   [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      phase_full[c] = MULT_W'(pos_scaled) * MULT_W'(freq[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NCH; c++) begin
        s1_phase[c] <= phase_full[c][PHASE_BITS-1:0];
      end
    end
  end

  // Stage 2: quarter-wave table lookup
  logic [TABLE_BITS-1:0] tab_idx  [NCH];
  logic [QTR_BITS-1:0]   qtr_low  [NCH];
  logic [QTR_BITS-1:0]   qtr_idx  [NCH];
  logic                  qtr_zero [NCH];
  logic                  qtr_neg  [NCH];
  logic [MAG_W-1:0]      s2_mag   [NCH];
  logic                  s2_neg   [NCH];

  for (genvar c = 0; c < NCH; c++) begin : g_idx
    if (PHASE_BITS >= TABLE_BITS) begin : g_top
      assign tab_idx[c] = s1_phase[c][PHASE_BITS-1 -: TABLE_BITS];
    end else begin : g_pad
      assign tab_idx[c] = {s1_phase[c], {(TABLE_BITS - PHASE_BITS){1'b0}}};
    end
  end

  // odd quadrants run the table backwards; their first entry is zero
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      qtr_low[c]  = tab_idx[c][QTR_BITS-1:0];
      qtr_idx[c]  = tab_idx[c][QTR_BITS] ? -qtr_low[c] : qtr_low[c];
      qtr_zero[c] = tab_idx[c][QTR_BITS] && (qtr_low[c] == '0);
      qtr_neg[c]  = tab_idx[c][TABLE_BITS-1] ^ tab_idx[c][QTR_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NCH; c++) begin
        s2_mag[c] <= qtr_zero[c] ? '0 : cos_rom[qtr_idx[c]];
        s2_neg[c] <= qtr_neg[c];
      end
    end
  end

  // Stage 3: swing * |cosine|
  logic [PROD_W-1:0] s3_prod [NCH];
  logic              s3_neg  [NCH];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NCH; c++) begin
        s3_prod[c] <= PROD_W'(swing) * PROD_W'(s2_mag[c]);
        s3_neg[c]  <= s2_neg[c];
      end
    end
  end

  // Stage 4: base minus swing * signed cosine, floor, clamp
  logic signed [NUM_W-1:0] base_ext;
  logic signed [NUM_W-1:0] prod_ext [NCH];
  logic signed [NUM_W-1:0] num  [NCH];
  logic [QUOT_W-1:0]       quot [NCH];
  color_t                  chan [NCH];
  color_t                  out_color [NCH];

  assign base_ext = $signed({{(NUM_W - LEVEL_W - COS_FRAC_BITS){1'b0}}, base_level,
                             {COS_FRAC_BITS{1'b0}}});

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod_ext[c] = $signed({1'b0, s3_prod[c]});
      num[c]  = s3_neg[c] ? base_ext + prod_ext[c] : base_ext - prod_ext[c];
      quot[c] = num[c][NUM_W-1:COS_FRAC_BITS];
      if (num[c] < 0) begin
        chan[c] = '0;
      end else if (quot[c] > QUOT_W'(255)) begin
        chan[c] = 8'd255;
      end else begin
        chan[c] = quot[c][COLOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NCH; c++) begin
        out_color[c] <= chan[c];
      end
    end
  end

  assign color_out.valid = out_valid;
  assign color_out.red   = out_color[0];
  assign color_out.green = out_color[1];
  assign color_out.blue  = out_color[2];

  `CPC_ASSERT_NEXT(a_accept_enters, clk, rst, in_fire, s1_valid, "accepted beat lost")
  `CPC_ASSERT_NEXT(a_stall_holds, clk, rst, !adv, $stable(valid_vec), "valid bits moved in stall")
  `CPC_ASSERT_NEXT(a_drain_out, clk, rst, s3_valid && adv, out_valid, "stage 3 beat lost")
  `CPC_ASSERT_NOW(a_stall_cause, clk, rst, !adv, out_stall, "stall without blocked beat")

endmodule
